[hdl/triangle_point_height_interp_core_macros.svh]
// Assertion macros for the checker module tpi_chk.
`ifndef TRIANGLE_POINT_HEIGHT_INTERP_CORE_MACROS_SVH
`define TRIANGLE_POINT_HEIGHT_INTERP_CORE_MACROS_SVH

// Implication in the same cycle, off while reset is asserted.
`define TPI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, off while reset is asserted.
`define TPI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Implication in the next cycle, checked through reset.
`define TPI_ASSERT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/tpi_pkg.sv]
`default_nettype none
package tpi_pkg;

    // Top-left flags of the edges a->b, b->c and c->a
    typedef struct packed {
        logic t0;
        logic t1;
        logic t2;
    } t_tie;

    // Stage control that travels with the data
    typedef struct packed {
        logic vld;
        logic hit;
    } t_ctl;

endpackage
`default_nettype wire

[hdl/tpi_in_if.sv]
`default_nettype none
interface tpi_in_if #(
    parameter int COORD_BITS  = 14,
    parameter int HEIGHT_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  ax;
    logic signed [COORD_BITS-1:0]  az;
    logic signed [HEIGHT_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0]  bx;
    logic signed [COORD_BITS-1:0]  bz;
    logic signed [HEIGHT_BITS-1:0] by;
    logic signed [COORD_BITS-1:0]  cx;
    logic signed [COORD_BITS-1:0]  cz;
    logic signed [HEIGHT_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0]  point_x;
    logic signed [COORD_BITS-1:0]  point_z;

    modport source (
        output valid, ax, az, ay, bx, bz, by, cx, cz, cy, point_x, point_z,
        input  ready
    );
    modport sink (
        input  valid, ax, az, ay, bx, bz, by, cx, cz, cy, point_x, point_z,
        output ready
    );
endinterface
`default_nettype wire

[hdl/tpi_out_if.sv]
`default_nettype none
interface tpi_out_if #(
    parameter int HEIGHT_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic                          inside_res;
    logic signed [HEIGHT_BITS-1:0] height;

    modport source (output valid, inside_res, height, input ready);
    modport sink   (input  valid, inside_res, height, output ready);
endinterface
`default_nettype wire

[hdl/tpi_front.sv]
`default_nettype none
module tpi_front #(
    parameter int COORD_BITS  = 14,
    parameter int HEIGHT_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic signed [COORD_BITS-1:0]  i_ax,
    input  wire logic signed [COORD_BITS-1:0]  i_az,
    input  wire logic signed [HEIGHT_BITS-1:0] i_ay,
    input  wire logic signed [COORD_BITS-1:0]  i_bx,
    input  wire logic signed [COORD_BITS-1:0]  i_bz,
    input  wire logic signed [HEIGHT_BITS-1:0] i_by,
    input  wire logic signed [COORD_BITS-1:0]  i_cx,
    input  wire logic signed [COORD_BITS-1:0]  i_cz,
    input  wire logic signed [HEIGHT_BITS-1:0] i_cy,
    input  wire logic signed [COORD_BITS-1:0]  i_px,
    input  wire logic signed [COORD_BITS-1:0]  i_pz,
    output logic                               o_vld,
    output tpi_pkg::t_tie                      o_tie,
    output logic signed [2*COORD_BITS+2:0]     o_e0,
    output logic signed [2*COORD_BITS+2:0]     o_e1,
    output logic signed [2*COORD_BITS+2:0]     o_e2,
    output logic signed [2*COORD_BITS+2:0]     o_area,
    output logic signed [HEIGHT_BITS-1:0]      o_ay,
    output logic signed [HEIGHT_BITS-1:0]      o_by,
    output logic signed [HEIGHT_BITS-1:0]      o_cy
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int EW = 2 * COORD_BITS + 3;

    tpi_pkg::t_tie n_tie;

    logic                          r_s1_vld, r_s2_vld, r_s3_vld;
    tpi_pkg::t_tie                 r_s1_tie, r_s2_tie, r_s3_tie;
    logic signed [DW-1:0]          r_s1_pax, r_s1_paz, r_s1_pbx, r_s1_pbz, r_s1_pcx, r_s1_pcz;
    logic signed [DW-1:0]          r_s1_dx0, r_s1_dx1, r_s1_dx2, r_s1_dz0, r_s1_dz1, r_s1_dz2;
    logic signed [DW-1:0]          r_s1_acx, r_s1_acz;
    logic signed [HEIGHT_BITS-1:0] r_s1_ay, r_s1_by, r_s1_cy;
    logic signed [HEIGHT_BITS-1:0] r_s2_ay, r_s2_by, r_s2_cy;
    logic signed [HEIGHT_BITS-1:0] r_s3_ay, r_s3_by, r_s3_cy;
    logic signed [PW-1:0]          r_s2_m0a, r_s2_m0b, r_s2_m1a, r_s2_m1b;
    logic signed [PW-1:0]          r_s2_m2a, r_s2_m2b, r_s2_mra, r_s2_mrb;
    logic signed [EW-1:0]          r_s3_e0, r_s3_e1, r_s3_e2, r_s3_area;

    // An edge is top or left when its z step is positive, or flat with the
    // remaining vertex ordered as given.
    always_comb begin
        n_tie.t0 = ((i_az == i_bz) && (i_bz > i_cz)) || (i_az < i_bz);
        n_tie.t1 = ((i_bz == i_cz) && (i_cz > i_az)) || (i_bz < i_cz);
        n_tie.t2 = ((i_cz == i_az) && (i_az > i_bz)) || (i_cz < i_az);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // differences
            r_s1_tie <= n_tie;
            r_s1_pax <= DW'(i_px) - DW'(i_ax);
            r_s1_paz <= DW'(i_pz) - DW'(i_az);
            r_s1_pbx <= DW'(i_px) - DW'(i_bx);
            r_s1_pbz <= DW'(i_pz) - DW'(i_bz);
            r_s1_pcx <= DW'(i_px) - DW'(i_cx);
            r_s1_pcz <= DW'(i_pz) - DW'(i_cz);
            r_s1_dx0 <= DW'(i_ax) - DW'(i_bx);
            r_s1_dx1 <= DW'(i_bx) - DW'(i_cx);
            r_s1_dx2 <= DW'(i_cx) - DW'(i_ax);
            r_s1_dz0 <= DW'(i_az) - DW'(i_bz);
            r_s1_dz1 <= DW'(i_bz) - DW'(i_cz);
            r_s1_dz2 <= DW'(i_cz) - DW'(i_az);
            r_s1_acx <= DW'(i_ax) - DW'(i_cx);
            r_s1_acz <= DW'(i_az) - DW'(i_cz);
            r_s1_ay  <= i_ay;
            r_s1_by  <= i_by;
            r_s1_cy  <= i_cy;
            // cross products
            r_s2_tie <= r_s1_tie;
            r_s2_m0a <= PW'(r_s1_pax) * PW'(r_s1_dz0);
            r_s2_m0b <= PW'(r_s1_paz) * PW'(r_s1_dx0);
            r_s2_m1a <= PW'(r_s1_pbx) * PW'(r_s1_dz1);
            r_s2_m1b <= PW'(r_s1_pbz) * PW'(r_s1_dx1);
            r_s2_m2a <= PW'(r_s1_pcx) * PW'(r_s1_dz2);
            r_s2_m2b <= PW'(r_s1_pcz) * PW'(r_s1_dx2);
            r_s2_mra <= PW'(r_s1_acx) * PW'(r_s1_dz1);
            r_s2_mrb <= PW'(r_s1_acz) * PW'(r_s1_dx1);
            r_s2_ay  <= r_s1_ay;
            r_s2_by  <= r_s1_by;
            r_s2_cy  <= r_s1_cy;
            // edge values and area
            r_s3_tie  <= r_s2_tie;
            r_s3_e0   <= EW'(r_s2_m0a) - EW'(r_s2_m0b);
            r_s3_e1   <= EW'(r_s2_m1a) - EW'(r_s2_m1b);
            r_s3_e2   <= EW'(r_s2_m2a) - EW'(r_s2_m2b);
            r_s3_area <= EW'(r_s2_mra) - EW'(r_s2_mrb);
            r_s3_ay   <= r_s2_ay;
            r_s3_by   <= r_s2_by;
            r_s3_cy   <= r_s2_cy;
        end
    end

    assign o_vld  = r_s3_vld;
    assign o_tie  = r_s3_tie;
    assign o_e0   = r_s3_e0;
    assign o_e1   = r_s3_e1;
    assign o_e2   = r_s3_e2;
    assign o_area = r_s3_area;
    assign o_ay   = r_s3_ay;
    assign o_by   = r_s3_by;
    assign o_cy   = r_s3_cy;
endmodule
`default_nettype wire

[hdl/tpi_wsum.sv]
`default_nettype none
module tpi_wsum #(
    parameter int COORD_BITS  = 14,
    parameter int HEIGHT_BITS = 32
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_en,
    input  wire logic                                        i_vld,
    input  wire tpi_pkg::t_tie                               i_tie,
    input  wire logic signed [2*COORD_BITS+2:0]              i_e0,
    input  wire logic signed [2*COORD_BITS+2:0]              i_e1,
    input  wire logic signed [2*COORD_BITS+2:0]              i_e2,
    input  wire logic signed [2*COORD_BITS+2:0]              i_area,
    input  wire logic signed [HEIGHT_BITS-1:0]               i_ay,
    input  wire logic signed [HEIGHT_BITS-1:0]               i_by,
    input  wire logic signed [HEIGHT_BITS-1:0]               i_cy,
    output tpi_pkg::t_ctl                                    o_ctl,
    output logic signed [2*COORD_BITS+HEIGHT_BITS+4:0]       o_num,
    output logic        [2*COORD_BITS+1:0]                   o_area
);
    localparam int EW = 2 * COORD_BITS + 3;
    localparam int AW = 2 * COORD_BITS + 2;
    localparam int MW = EW + HEIGHT_BITS;
    localparam int NW = MW + 2;

    logic          n_neg0, n_neg1, n_neg2, n_allz;
    tpi_pkg::t_ctl n_ctl;

    tpi_pkg::t_ctl        r_s4_ctl, r_s5_ctl;
    logic signed [MW-1:0] r_s4_p0, r_s4_p1, r_s4_p2;
    logic [AW-1:0]        r_s4_area, r_s5_area;
    logic signed [NW-1:0] r_s5_num;

    always_comb begin
        n_neg0 = (i_e0 < 0) || (i_tie.t0 && (i_e0 == '0));
        n_neg1 = (i_e1 < 0) || (i_tie.t1 && (i_e1 == '0));
        n_neg2 = (i_e2 < 0) || (i_tie.t2 && (i_e2 == '0));
        n_allz = (i_e0 == '0) && (i_e1 == '0) && (i_e2 == '0);
        n_ctl.vld = i_vld;
        n_ctl.hit = !n_neg0 && !n_neg1 && !n_neg2 && !n_allz && (i_area != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl <= '0;
            r_s5_ctl <= '0;
        end else if (i_en) begin
            r_s4_ctl <= n_ctl;
            r_s5_ctl <= r_s4_ctl;
        end
    end

    // Inside implies a positive area, so its low bits carry it unsigned.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_p0   <= MW'(i_e0) * MW'(i_by);
            r_s4_p1   <= MW'(i_e1) * MW'(i_cy);
            r_s4_p2   <= MW'(i_e2) * MW'(i_ay);
            r_s4_area <= i_area[AW-1:0];
            r_s5_num  <= NW'(r_s4_p0) + NW'(r_s4_p1) + NW'(r_s4_p2);
            r_s5_area <= r_s4_area;
        end
    end

    assign o_ctl  = r_s5_ctl;
    assign o_num  = r_s5_num;
    assign o_area = r_s5_area;
endmodule
`default_nettype wire

[hdl/tpi_div.sv]
`default_nettype none
module tpi_div #(
    parameter int COORD_BITS  = 14,
    parameter int HEIGHT_BITS = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire tpi_pkg::t_ctl                         i_ctl,
    input  wire logic signed [2*COORD_BITS+HEIGHT_BITS+4:0] i_num,
    input  wire logic        [2*COORD_BITS+1:0]        i_area,
    output tpi_pkg::t_ctl                              o_ctl,
    output logic signed [HEIGHT_BITS-1:0]              o_height
);
    localparam int AW  = 2 * COORD_BITS + 2;
    localparam int NW  = 2 * COORD_BITS + HEIGHT_BITS + 5;
    localparam int QW  = HEIGHT_BITS + 1;
    localparam int DVW = AW + QW;
    localparam logic [QW-1:0] HMAX = {2'b00, {(HEIGHT_BITS-1){1'b1}}};

    logic [NW-1:0]          n_mag;
    logic [QW-1:0]          n_negq;
    logic [HEIGHT_BITS-1:0] n_h;

    tpi_pkg::t_ctl          r_ctl [0:QW];
    logic [AW-1:0]          r_rem [0:QW];
    logic [QW-1:0]          r_low [0:QW];
    logic [AW-1:0]          r_area[0:QW];
    logic                   r_sgn [0:QW];
    tpi_pkg::t_ctl          r_o_ctl;
    logic [HEIGHT_BITS-1:0] r_o_h;

    // Magnitude; inside keeps it below area * 2^QW, so the top part is a
    // valid starting remainder.
    assign n_mag = i_num[NW-1] ? (NW'(0) - NW'(i_num)) : NW'(i_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_mag[DVW-1:QW];
            r_low[0]  <= n_mag[QW-1:0];
            r_area[0] <= i_area;
            r_sgn[0]  <= i_num[NW-1];
        end
    end

    // One quotient bit per stage: shift in a dividend bit, subtract if it fits.
    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [AW:0] w_t;
        logic        w_ge;
        logic [AW:0] w_d;

        assign w_t  = {r_rem[k-1], r_low[k-1][QW-1]};
        assign w_ge = (w_t >= {1'b0, r_area[k-1]});
        assign w_d  = w_t - {1'b0, r_area[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_en) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_d[AW-1:0] : w_t[AW-1:0];
                r_low[k]  <= {r_low[k-1][QW-2:0], w_ge};
                r_area[k] <= r_area[k-1];
                r_sgn[k]  <= r_sgn[k-1];
            end
        end
    end

    // Negate the truncated signed quotient, or give zero when outside; only the most positive height saturates.
    always_comb begin
        n_negq = QW'(0) - r_low[QW];
        if (!r_ctl[QW].hit) begin
            n_h = '0;
        end else if (r_sgn[QW]) begin
            n_h = (r_low[QW] > HMAX) ? HMAX[HEIGHT_BITS-1:0] : r_low[QW][HEIGHT_BITS-1:0];
        end else begin
            n_h = n_negq[HEIGHT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_ctl <= '0;
        end else if (i_en) begin
            r_o_ctl <= r_ctl[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_h <= n_h;
        end
    end

    assign o_ctl    = r_o_ctl;
    assign o_height = signed'(r_o_h);
endmodule
`default_nettype wire

[hdl/triangle_point_height_interp_core.sv]
`default_nettype none
// Point-in-triangle test with height interpolation in the x-z plane. Each
// transfer on i_in carries one triangle and one query point; each transfer on
// o_out returns inside_res and the negated barycentric height (Q16.16), which
// is zero when the point is outside. Zero edge values on top or left edges
// count as outside, and a degenerate triangle never contains the point.
// The block takes one transfer per clock while i_in.ready is high. From input
// transfer to o_out, the data passes the edge arithmetic, the weighted sum,
// the register that takes the dividend magnitude, the pipelined restoring
// divider (one quotient bit per stage), the register that negates and
// saturates, and the output register. A two-entry output buffer lets the
// pipeline run on while a result waits; once both entries hold, i_in.ready
// drops until o_out takes one.
module triangle_point_height_interp_core #(
    parameter int COORD_BITS  = 14,
    parameter int HEIGHT_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tpi_in_if.sink    i_in,
    tpi_out_if.source o_out
);
    localparam int EW = 2 * COORD_BITS + 3;
    localparam int AW = 2 * COORD_BITS + 2;
    localparam int NW = 2 * COORD_BITS + HEIGHT_BITS + 5;

    logic                          w_en;
    logic                          w_f_vld;
    tpi_pkg::t_tie                 w_f_tie;
    logic signed [EW-1:0]          w_e0, w_e1, w_e2, w_area;
    logic signed [HEIGHT_BITS-1:0] w_ay, w_by, w_cy;
    tpi_pkg::t_ctl                 w_s_ctl;
    logic signed [NW-1:0]          w_num;
    logic [AW-1:0]                 w_s_area;
    tpi_pkg::t_ctl                 w_d_ctl;
    logic signed [HEIGHT_BITS-1:0] w_d_h;

    logic                          r_o_vld, r_o_inside;
    logic signed [HEIGHT_BITS-1:0] r_o_height;
    logic                          r_k_vld, r_k_inside;
    logic signed [HEIGHT_BITS-1:0] r_k_height;

    // The whole pipeline advances together; hold it only while the spare
    // output entry is occupied.
    assign w_en       = !r_k_vld;
    assign i_in.ready = w_en;

    tpi_front #(.COORD_BITS(COORD_BITS), .HEIGHT_BITS(HEIGHT_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_ax    (i_in.ax),
        .i_az    (i_in.az),
        .i_ay    (i_in.ay),
        .i_bx    (i_in.bx),
        .i_bz    (i_in.bz),
        .i_by    (i_in.by),
        .i_cx    (i_in.cx),
        .i_cz    (i_in.cz),
        .i_cy    (i_in.cy),
        .i_px    (i_in.point_x),
        .i_pz    (i_in.point_z),
        .o_vld   (w_f_vld),
        .o_tie   (w_f_tie),
        .o_e0    (w_e0),
        .o_e1    (w_e1),
        .o_e2    (w_e2),
        .o_area  (w_area),
        .o_ay    (w_ay),
        .o_by    (w_by),
        .o_cy    (w_cy)
    );

    tpi_wsum #(.COORD_BITS(COORD_BITS), .HEIGHT_BITS(HEIGHT_BITS)) u_wsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_tie   (w_f_tie),
        .i_e0    (w_e0),
        .i_e1    (w_e1),
        .i_e2    (w_e2),
        .i_area  (w_area),
        .i_ay    (w_ay),
        .i_by    (w_by),
        .i_cy    (w_cy),
        .o_ctl   (w_s_ctl),
        .o_num   (w_num),
        .o_area  (w_s_area)
    );

    tpi_div #(.COORD_BITS(COORD_BITS), .HEIGHT_BITS(HEIGHT_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (w_s_ctl),
        .i_num    (w_num),
        .i_area   (w_s_area),
        .o_ctl    (w_d_ctl),
        .o_height (w_d_h)
    );

    // Output register plus spare entry. The pipeline result is consumed on
    // every cycle that w_en is high: into the output register when it is
    // free or being taken, else into the spare entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_k_vld <= 1'b0;
        end else if (o_out.ready || !r_o_vld) begin
            if (r_k_vld) begin
                r_o_vld <= 1'b1;
                r_k_vld <= 1'b0;
            end else begin
                r_o_vld <= w_d_ctl.vld;
            end
        end else if (w_en && w_d_ctl.vld) begin
            r_k_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out.ready || !r_o_vld) begin
            if (r_k_vld) begin
                r_o_inside <= r_k_inside;
                r_o_height <= r_k_height;
            end else begin
                r_o_inside <= w_d_ctl.hit;
                r_o_height <= w_d_h;
            end
        end else if (w_en) begin
            r_k_inside <= w_d_ctl.hit;
            r_k_height <= w_d_h;
        end
    end

    assign o_out.valid      = r_o_vld;
    assign o_out.inside_res = r_o_inside;
    assign o_out.height     = r_o_height;
endmodule
`default_nettype wire

[hdl/tpi_chk.sv]
`default_nettype none
`include "triangle_point_height_interp_core_macros.svh"
module tpi_chk #(
    parameter int HEIGHT_BITS = 32
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_ready,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic                   i_out_inside,
    input wire logic [HEIGHT_BITS-1:0] i_out_height
);
    `TPI_ASSERT_IMP(a_outside_zero, i_clk, i_rst_n, i_out_valid && !i_out_inside, i_out_height == '0, "outside result with nonzero height")
    `TPI_ASSERT_NXT(a_valid_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `TPI_ASSERT_NXT(a_data_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_height) && $stable(i_out_inside), "result changed while stalled")
    `TPI_ASSERT_RST(a_reset_clear, i_clk, !i_rst_n, i_in_ready && !i_out_valid, "not empty after reset")
endmodule

bind triangle_point_height_interp_core tpi_chk #(.HEIGHT_BITS(HEIGHT_BITS)) u_tpi_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_inside (o_out.inside_res),
    .i_out_height (o_out.height)
);
`default_nettype wire
